// ===== rtl/fla_pkg.sv =====
// Shared types, constants and helpers for the free-list block allocator.
// No dependencies; used by fla_link_ram's users and the top level.
`default_nettype none

package fla_pkg;

  // Pool capacity; the free_index and block_index ports are IdxW bits wide.
  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CountW    = 9;
  localparam int unsigned LinkW     = IdxW + 1;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_INIT    = 2'd2,
    OP_DESTROY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_ZERO_INIT  = 2'd2,
    ST_RESERVED   = 2'd3
  } status_e;

  // One next-link entry: end-of-list flag plus the following block index.
  typedef struct packed {
    logic            last;
    logic [IdxW-1:0] idx;
  } link_t;

  // Pool size minus used count, zero when used exceeds the pool.
  function automatic logic [CountW-1:0] free_cnt(input logic [CountW-1:0] pool,
                                                 input logic [CountW-1:0] used);
    logic [CountW-1:0] diff;
    diff = pool - used;
    return (pool > used) ? diff : '0;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fla_link_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the allocator's next-link entries; no package dependency.
`default_nettype none

module fla_link_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/free_list_block_allocator_top.sv =====
// Top level of the free-list block allocator: control sequencer plus link RAM.
// Depends on fla_pkg and fla_link_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation item:
//   alloc, free, init or destroy. Each item yields exactly one result item
//   on the output channel (out_valid_o/out_ready_i): status, block index and
//   the used and free counts after the operation.
//   cfg_we_i writes pool_blocks, the block count linked in by an init; write
//   it only while no item is in flight.
//   Results: free, destroy, rejected alloc and rejected init give their result
//   in the cycle after acceptance; an alloc from a non-empty list first passes
//   through the pop state (one read of the link RAM). Init writes one link per
//   cycle and links min(pool_blocks, 256) blocks.
//   One item is in flight at a time; a new item is taken in the cycle its
//   predecessor's result is taken, so free runs at one item per cycle when
//   the receiver never stalls; an alloc holds off new items during its pop.
//   Reset leaves the list empty, the counts zero and pool_blocks at 256; the
//   link RAM is not cleared. While the receiver stalls, the result is held
//   and no new item is accepted.
`default_nettype none

module free_list_block_allocator_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [fla_pkg::IdxW-1:0]    free_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [1:0]                  status_o,
  output logic      [fla_pkg::IdxW-1:0]    block_index_o,
  output logic      [fla_pkg::CountW-1:0]  used_count_o,
  output logic      [fla_pkg::CountW-1:0]  free_count_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [fla_pkg::CountW-1:0]  cfg_wdata_i
);

  localparam int unsigned IdxW   = fla_pkg::IdxW;
  localparam int unsigned CountW = fla_pkg::CountW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_INIT
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0] pool_blocks_q;
  logic [IdxW-1:0]   head_q, head_d;
  logic              head_valid_q, head_valid_d;
  logic [CountW-1:0] used_q, used_d;
  logic [CountW-1:0] pool_q, pool_d;
  logic [IdxW-1:0]   init_cnt_q, init_cnt_d;
  logic [IdxW-1:0]   init_last_q, init_last_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [IdxW-1:0]   block_q, block_d;
  logic [CountW-1:0] used_out_q, used_out_d;
  logic [CountW-1:0] free_out_q, free_out_d;

  logic                      ram_we, ram_re;
  logic [IdxW-1:0]           ram_waddr;
  fla_pkg::link_t            ram_wlink, rd_link;
  logic [fla_pkg::LinkW-1:0] ram_rdata;

  logic              in_fire;
  logic [CountW-1:0] init_n;
  logic [CountW-1:0] used_inc, used_dec;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_link    = fla_pkg::link_t'(ram_rdata);

  // Requested init size clamped to the pool capacity.
  assign init_n = (pool_blocks_q > CountW'(fla_pkg::MaxBlocks)) ?
                  CountW'(fla_pkg::MaxBlocks) : pool_blocks_q;

  assign used_inc = (used_q == fla_pkg::CountMax) ? used_q : used_q + 1'b1;
  assign used_dec = (used_q == '0) ? used_q : used_q - 1'b1;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    used_d       = used_q;
    pool_d       = pool_q;
    init_cnt_d   = init_cnt_q;
    init_last_d  = init_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    block_d      = block_q;
    used_out_d   = used_out_q;
    free_out_d   = free_out_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = free_index_i;
    ram_wlink    = '{last: !head_valid_q, idx: head_q};

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (fla_pkg::op_e'(operation_i))
            fla_pkg::OP_ALLOC: begin
              if (head_valid_q) begin
                ram_re  = 1'b1;
                state_d = S_POP;
              end else begin
                out_valid_d = 1'b1;
                status_d    = fla_pkg::ST_EMPTY;
                block_d     = '0;
                used_out_d  = used_q;
                free_out_d  = fla_pkg::free_cnt(pool_q, used_q);
              end
            end
            fla_pkg::OP_FREE: begin
              // push: new entry points at the old head
              ram_we       = 1'b1;
              head_d       = free_index_i;
              head_valid_d = 1'b1;
              used_d       = used_dec;
              out_valid_d  = 1'b1;
              status_d     = fla_pkg::ST_OK;
              block_d      = '0;
              used_out_d   = used_dec;
              free_out_d   = fla_pkg::free_cnt(pool_q, used_dec);
            end
            fla_pkg::OP_INIT: begin
              if (init_n == '0) begin
                out_valid_d = 1'b1;
                status_d    = fla_pkg::ST_ZERO_INIT;
                block_d     = '0;
                used_out_d  = used_q;
                free_out_d  = fla_pkg::free_cnt(pool_q, used_q);
              end else begin
                init_cnt_d  = '0;
                init_last_d = IdxW'(init_n - 1'b1);
                state_d     = S_INIT;
              end
            end
            default: begin
              head_d       = '0;
              head_valid_d = 1'b0;
              used_d       = '0;
              pool_d       = '0;
              out_valid_d  = 1'b1;
              status_d     = fla_pkg::ST_OK;
              block_d      = '0;
              used_out_d   = '0;
              free_out_d   = '0;
            end
          endcase
        end
      end

      S_POP: begin
        head_d       = rd_link.idx;
        head_valid_d = !rd_link.last;
        used_d       = used_inc;
        out_valid_d  = 1'b1;
        status_d     = fla_pkg::ST_OK;
        block_d      = head_q;
        used_out_d   = used_inc;
        free_out_d   = fla_pkg::free_cnt(pool_q, used_inc);
        state_d      = S_IDLE;
      end

      S_INIT: begin
        // block i links to i-1; block 0 ends the list
        ram_we    = 1'b1;
        ram_waddr = init_cnt_q;
        ram_wlink = '{last: (init_cnt_q == '0),
                      idx:  (init_cnt_q == '0) ? '0 : init_cnt_q - 1'b1};
        if (init_cnt_q == init_last_q) begin
          head_d       = init_last_q;
          head_valid_d = 1'b1;
          used_d       = '0;
          pool_d       = {1'b0, init_last_q} + 1'b1;
          out_valid_d  = 1'b1;
          status_d     = fla_pkg::ST_OK;
          block_d      = '0;
          used_out_d   = '0;
          free_out_d   = {1'b0, init_last_q} + 1'b1;
          state_d      = S_IDLE;
        end else begin
          init_cnt_d = init_cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pool_blocks_q <= CountW'(fla_pkg::MaxBlocks);
      head_q        <= '0;
      head_valid_q  <= 1'b0;
      used_q        <= '0;
      pool_q        <= '0;
      init_cnt_q    <= '0;
      init_last_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        pool_blocks_q <= cfg_wdata_i;
      end
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      used_q       <= used_d;
      pool_q       <= pool_d;
      init_cnt_q   <= init_cnt_d;
      init_last_q  <= init_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    block_q    <= block_d;
    used_out_q <= used_out_d;
    free_out_q <= free_out_d;
  end

  fla_link_ram #(
    .Depth (fla_pkg::MaxBlocks),
    .Width (fla_pkg::LinkW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wlink),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign block_index_o = block_q;
  assign used_count_o  = used_out_q;
  assign free_count_o  = free_out_q;

  // link RAM is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("link RAM read and write overlap");

  // a pop always completes with a result the next cycle
  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (out_valid_q && state_q == S_IDLE))
    else $error("pop did not produce a result");

  // alloc from a non-empty list goes through the link read
  a_alloc_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && operation_i == fla_pkg::OP_ALLOC && head_valid_q) |=> (state_q == S_POP))
    else $error("alloc skipped the link read");

  // init completion leaves a valid head at the top block
  a_init_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT && init_cnt_q == init_last_q)
      |=> (head_valid_q && head_q == $past(init_last_q) && used_q == '0))
    else $error("init left a wrong head");

endmodule

`default_nettype wire
